@@ design/clnb_pkg.sv @@
// Shared types and codes of the cell-list neighbour builder.
package clnb_pkg;

    typedef enum logic [2:0] {
        STAT_ATOM_STORED = 3'd0,
        STAT_CELL_RANGE  = 3'd1,
        STAT_SITE_RANGE  = 3'd2,
        STAT_PAIR        = 3'd3,
        STAT_NO_PAIR     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_TEMPLATE = 2'd0,
        MODE_ATOM     = 2'd1,
        MODE_QUERY    = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_PERIODIC = 3'd0,
        REG_GRID_X   = 3'd1,
        REG_GRID_Y   = 3'd2,
        REG_GRID_Z   = 3'd3,
        REG_LEN_X    = 3'd4,
        REG_LEN_Y    = 3'd5,
        REG_LEN_Z    = 3'd6,
        REG_SITES    = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TRD,
        S_CI,
        S_CJ,
        S_AI,
        S_AJ,
        S_OUT
    } fsm_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_PLUS,
        SH_MINUS
    } shift_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] n;
        shift_t     sh;
    } wrap_t;

endpackage

@@ design/clnb_if.sv @@
// Channel interfaces: input word, result word and configuration write.
interface clnb_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [5:0]        cell_x;
    logic [5:0]        cell_y;
    logic [5:0]        cell_z;
    logic [4:0]        site_a;
    logic [3:0]        site_b;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [3:0] off_x;
    logic signed [3:0] off_y;
    logic signed [3:0] off_z;

    modport source (output valid, mode, cell_x, cell_y, cell_z, site_a, site_b,
                    pos_x, pos_y, pos_z, off_x, off_y, off_z, input ready);
    modport sink (input valid, mode, cell_x, cell_y, cell_z, site_a, site_b,
                  pos_x, pos_y, pos_z, off_x, off_y, off_z, output ready);
endinterface

interface clnb_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [15:0]        atom_i;
    logic [15:0]        atom_j;
    logic [5:0]         template_index;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic               last;

    modport source (output valid, status, atom_i, atom_j, template_index,
                    vec_x, vec_y, vec_z, last, input ready);
    modport sink (input valid, status, atom_i, atom_j, template_index,
                  vec_x, vec_y, vec_z, last, output ready);
endinterface

interface clnb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [30:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/clnb_wrap.sv @@
// Neighbour cell coordinate along one axis with at most one periodic wrap.
module clnb_wrap (
    input  logic              [5:0] c,
    input  logic signed       [3:0] off,
    input  logic              [5:0] g,
    input  logic                    per,
    output clnb_pkg::wrap_t         res
);
    import clnb_pkg::*;

    logic signed [7:0] v;
    logic signed [7:0] vw;
    logic signed [7:0] gs;
    shift_t            sh;

    always_comb
    begin
        gs = $signed({2'b00, g});
        v  = $signed({2'b00, c}) + 8'(off);
        vw = v;
        sh = SH_NONE;
        if (per)
        begin
            if (v >= gs)
            begin
                vw = v - gs;
                sh = SH_PLUS;
            end
            else if (v < 8'sd0)
            begin
                vw = v + gs;
                sh = SH_MINUS;
            end
        end
        res.ok = (vw >= 8'sd0) && (vw < gs);
        res.n  = vw[5:0];
        res.sh = sh;
    end
endmodule

@@ design/cell_list_neighbour_builder.sv @@
// Cell-list neighbour builder: template, atom store and cell/site lookup.
//
// Channels: req takes one input word (mode 0 template entry, 1 atom, 2 cell
// query, 3 clear); res gives result words; cfg writes the registers and is
// ready whenever reset is released. A word is moved when valid and ready are
// both high.
// Mode 0 and mode 3 give no result. Mode 1 gives one result, set in the
// output register from the dispatch state. Mode 2 gives one result per
// template entry, in table order: each entry needs a template
// read, two lookup-table reads and two atom-store reads through the single
// read port of each memory. A query of a cell outside the grid gives one
// result. The next word is accepted once the current one is finished.
// The lookup table keeps atom numbers only; an entry counts as filled when
// its number is below the atom count and that atom points back at the slot,
// so reset and clear take effect at once with no clearing pass.
// Reset empties the stores and restores the register defaults; req and cfg
// are ready from the first cycle after reset is released. When res stalls,
// the result holds in the output register and the walk waits.
module cell_list_neighbour_builder #(
    parameter int MAX_ATOMS    = 65536,
    parameter int MAX_GRID     = 32,
    parameter int MAX_SITES    = 16,
    parameter int MAX_TEMPLATE = 64
) (
    input logic       clk,
    input logic       rst_n,
    clnb_in_if.sink   req,
    clnb_out_if.source res,
    clnb_cfg_if.sink  cfg
);
    import clnb_pkg::*;

    localparam int AB     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int GB     = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int SB     = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int TB     = (MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE) : 1;
    localparam int SLOT_W = 3 * GB + SB;
    localparam int TM_W   = 2 * SB + 12;
    localparam int AM_W   = 96 + SLOT_W;

    function automatic logic [SLOT_W-1:0] slot_of(logic [5:0] x, logic [5:0] y,
                                                  logic [5:0] z, logic [7:0] s);
        logic [8:0] ex;
        logic [8:0] ey;
        logic [8:0] ez;
        logic [8:0] es;
        ex = 9'(x);
        ey = 9'(y);
        ez = 9'(z);
        es = 9'(s);
        return {ex[GB-1:0], ey[GB-1:0], ez[GB-1:0], es[SB-1:0]};
    endfunction

    // configuration
    logic [2:0]  periodic_reg;
    logic [5:0]  grid_reg [3];
    logic [30:0] len_reg [3];
    logic [4:0]  sites_reg;
    logic [31:0] shift_reg [3];
    logic [5:0]  g_eff [3];
    logic [4:0]  spc_eff;

    // latched input word
    mode_t             mode_reg;
    logic [5:0]        c_reg [3];
    logic [4:0]        sa_in_reg;
    logic [3:0]        sb_in_reg;
    logic [31:0]       pos_reg [3];
    logic signed [3:0] off_reg [3];

    // sequencer
    fsm_t              state_reg, state_next;
    logic [TB-1:0]     t_reg, t_next;
    logic [TB:0]       tcount_reg, tcount_next;
    logic [AB:0]       acount_reg, acount_next;
    logic              ok_reg, ok_next;
    logic [SLOT_W-1:0] sloti_reg, sloti_next;
    logic [SLOT_W-1:0] slotj_reg, slotj_next;
    shift_t            sh_reg [3];
    shift_t            sh_next [3];
    logic [AB-1:0]     ai_reg, ai_next;
    logic [AB-1:0]     aj_reg, aj_next;
    logic              vi_reg, vi_next;
    logic [31:0]       pi_reg [3];
    logic [31:0]       pi_next [3];

    // output register
    logic        ovalid_reg, ovalid_next;
    status_t     ostatus_reg, ostatus_next;
    logic [15:0] oai_reg, oai_next;
    logic [15:0] oaj_reg, oaj_next;
    logic [5:0]  oti_reg, oti_next;
    logic [31:0] ovec_reg [3];
    logic [31:0] ovec_next [3];
    logic        olast_reg, olast_next;

    // memories
    logic [TM_W-1:0]   tmem [MAX_TEMPLATE];
    logic [AB-1:0]     cmem [2**SLOT_W];
    logic [AM_W-1:0]   amem [MAX_ATOMS];
    logic              tm_we, tm_re;
    logic [TB-1:0]     tm_raddr;
    logic [TM_W-1:0]   tm_wdata, tm_rdata;
    logic              cm_we, cm_re;
    logic [SLOT_W-1:0] cm_waddr, cm_raddr;
    logic [AB-1:0]     cm_rdata;
    logic              am_we, am_re;
    logic [AB-1:0]     am_raddr;
    logic [AM_W-1:0]   am_wdata, am_rdata;

    wrap_t             w [3];
    logic [SB-1:0]     t_sa, t_sb;
    logic signed [3:0] t_off [3];
    logic              cell_ok;
    logic              out_free;
    logic              tw_ok;
    logic [31:0]       pj [3];
    logic [31:0]       shv;
    logic              vj;

    assign req.ready = rst_n && (state_reg == S_IDLE);
    assign cfg.ready = rst_n;

    assign res.valid          = ovalid_reg;
    assign res.status         = ostatus_reg;
    assign res.atom_i         = oai_reg;
    assign res.atom_j         = oaj_reg;
    assign res.template_index = oti_reg;
    assign res.vec_x          = ovec_reg[0];
    assign res.vec_y          = ovec_reg[1];
    assign res.vec_z          = ovec_reg[2];
    assign res.last           = olast_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (grid_reg[a] == 6'd0)
                g_eff[a] = 6'd1;
            else if ({3'b000, grid_reg[a]} > 9'(MAX_GRID))
                g_eff[a] = 6'(MAX_GRID);
            else
                g_eff[a] = grid_reg[a];
        end
        if (sites_reg == 5'd0)
            spc_eff = 5'd1;
        else if ({4'b0000, sites_reg} > 9'(MAX_SITES))
            spc_eff = 5'(MAX_SITES);
        else
            spc_eff = sites_reg;
    end

    assign cell_ok = (c_reg[0] < g_eff[0]) && (c_reg[1] < g_eff[1]) && (c_reg[2] < g_eff[2]);

    assign t_sa     = tm_rdata[TM_W-1 -: SB];
    assign t_sb     = tm_rdata[TM_W-SB-1 -: SB];
    assign t_off[0] = $signed(tm_rdata[11:8]);
    assign t_off[1] = $signed(tm_rdata[7:4]);
    assign t_off[2] = $signed(tm_rdata[3:0]);

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        clnb_wrap u_wrap (
            .c   (c_reg[a]),
            .off (t_off[a]),
            .g   (g_eff[a]),
            .per (periodic_reg[a]),
            .res (w[a])
        );
    end

    assign pj[0] = am_rdata[AM_W-1 -: 32];
    assign pj[1] = am_rdata[AM_W-33 -: 32];
    assign pj[2] = am_rdata[SLOT_W+31 -: 32];
    assign vj    = ({1'b0, aj_reg} < acount_reg) && (am_rdata[SLOT_W-1:0] == slotj_reg);

    assign tw_ok = (tcount_reg < (TB+1)'(MAX_TEMPLATE))
                && ({4'b0000, sa_in_reg} < 9'(MAX_SITES))
                && ({5'b00000, sb_in_reg} < 9'(MAX_SITES));

    always_comb
    begin
        logic [8:0] ea;
        logic [8:0] eb;
        ea = 9'(sa_in_reg);
        eb = 9'(sb_in_reg);
        tm_wdata = {ea[SB-1:0], eb[SB-1:0], off_reg[0], off_reg[1], off_reg[2]};
        am_wdata = {pos_reg[0], pos_reg[1], pos_reg[2],
                    slot_of(c_reg[0], c_reg[1], c_reg[2], 8'(sa_in_reg))};
        cm_waddr = slot_of(c_reg[0], c_reg[1], c_reg[2], 8'(sa_in_reg));
    end

    always_comb
    begin
        state_next   = state_reg;
        t_next       = t_reg;
        tcount_next  = tcount_reg;
        acount_next  = acount_reg;
        ok_next      = ok_reg;
        sloti_next   = sloti_reg;
        slotj_next   = slotj_reg;
        ai_next      = ai_reg;
        aj_next      = aj_reg;
        vi_next      = vi_reg;
        ovalid_next  = ovalid_reg;
        ostatus_next = ostatus_reg;
        oai_next     = oai_reg;
        oaj_next     = oaj_reg;
        oti_next     = oti_reg;
        olast_next   = olast_reg;
        shv          = 32'd0;
        for (int a = 0; a < 3; a++)
        begin
            sh_next[a]   = sh_reg[a];
            pi_next[a]   = pi_reg[a];
            ovec_next[a] = ovec_reg[a];
        end
        tm_we    = 1'b0;
        tm_re    = 1'b0;
        tm_raddr = t_reg;
        cm_we    = 1'b0;
        cm_re    = 1'b0;
        cm_raddr = sloti_reg;
        am_we    = 1'b0;
        am_re    = 1'b0;
        am_raddr = ai_reg;

        out_free = !ovalid_reg || res.ready;
        if (ovalid_reg && res.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (mode_reg)
                    MODE_TEMPLATE:
                    begin
                        if (tw_ok)
                        begin
                            tm_we       = 1'b1;
                            tcount_next = tcount_reg + 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    MODE_ATOM:
                    begin
                        if (out_free)
                        begin
                            ovalid_next = 1'b1;
                            oai_next    = 16'(acount_reg);
                            oaj_next    = 16'd0;
                            oti_next    = 6'd0;
                            olast_next  = 1'b1;
                            for (int a = 0; a < 3; a++)
                                ovec_next[a] = 32'd0;
                            if (!cell_ok || acount_reg >= (AB+1)'(MAX_ATOMS))
                                ostatus_next = STAT_CELL_RANGE;
                            else if (sa_in_reg >= spc_eff)
                                ostatus_next = STAT_SITE_RANGE;
                            else
                            begin
                                ostatus_next = STAT_ATOM_STORED;
                                am_we        = 1'b1;
                                cm_we        = 1'b1;
                                acount_next  = acount_reg + 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    MODE_QUERY:
                    begin
                        if (!cell_ok)
                        begin
                            if (out_free)
                            begin
                                ovalid_next  = 1'b1;
                                ostatus_next = STAT_CELL_RANGE;
                                oai_next     = 16'd0;
                                oaj_next     = 16'd0;
                                oti_next     = 6'd0;
                                olast_next   = 1'b1;
                                for (int a = 0; a < 3; a++)
                                    ovec_next[a] = 32'd0;
                                state_next = S_IDLE;
                            end
                        end
                        else if (tcount_reg == '0)
                            state_next = S_IDLE;
                        else
                        begin
                            t_next     = '0;
                            state_next = S_TRD;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        acount_next = '0;
                        state_next  = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TRD:
            begin
                tm_re      = 1'b1;
                state_next = S_CI;
            end
            S_CI:
            begin
                ok_next = w[0].ok && w[1].ok && w[2].ok
                       && (9'(t_sa) < 9'(spc_eff)) && (9'(t_sb) < 9'(spc_eff));
                sloti_next = slot_of(c_reg[0], c_reg[1], c_reg[2], 8'(t_sa));
                slotj_next = slot_of(w[0].n, w[1].n, w[2].n, 8'(t_sb));
                for (int a = 0; a < 3; a++)
                    sh_next[a] = w[a].sh;
                cm_re      = 1'b1;
                cm_raddr   = sloti_next;
                state_next = S_CJ;
            end
            S_CJ:
            begin
                ai_next    = cm_rdata;
                cm_re      = 1'b1;
                cm_raddr   = slotj_reg;
                state_next = S_AI;
            end
            S_AI:
            begin
                aj_next    = cm_rdata;
                am_re      = 1'b1;
                am_raddr   = ai_reg;
                state_next = S_AJ;
            end
            S_AJ:
            begin
                vi_next = ({1'b0, ai_reg} < acount_reg)
                       && (am_rdata[SLOT_W-1:0] == sloti_reg);
                for (int a = 0; a < 3; a++)
                    pi_next[a] = pj[a];
                am_re      = 1'b1;
                am_raddr   = aj_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oti_next    = 6'(t_reg);
                    olast_next  = (({1'b0, t_reg} + 1'b1) == tcount_reg);
                    if (ok_reg && vi_reg && vj)
                    begin
                        ostatus_next = STAT_PAIR;
                        oai_next     = 16'(ai_reg);
                        oaj_next     = 16'(aj_reg);
                        for (int a = 0; a < 3; a++)
                        begin
                            case (sh_reg[a])
                                SH_PLUS:  shv = shift_reg[a];
                                SH_MINUS: shv = 32'd0 - shift_reg[a];
                                default:  shv = 32'd0;
                            endcase
                            ovec_next[a] = shv + (pj[a] - pi_reg[a]);
                        end
                    end
                    else
                    begin
                        ostatus_next = STAT_NO_PAIR;
                        oai_next     = 16'd0;
                        oaj_next     = 16'd0;
                        for (int a = 0; a < 3; a++)
                            ovec_next[a] = 32'd0;
                    end
                    t_next = t_reg + 1'b1;
                    if (({1'b0, t_reg} + 1'b1) == tcount_reg)
                        state_next = S_IDLE;
                    else
                        state_next = S_TRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tcount_reg   <= '0;
            acount_reg   <= '0;
            ovalid_reg   <= 1'b0;
            periodic_reg <= 3'd0;
            sites_reg    <= 5'd1;
            for (int a = 0; a < 3; a++)
            begin
                grid_reg[a] <= 6'd1;
                len_reg[a]  <= 31'd0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            tcount_reg <= tcount_next;
            acount_reg <= acount_next;
            ovalid_reg <= ovalid_next;
            if (cfg.valid)
            begin
                case (reg_idx_t'(cfg.index))
                    REG_PERIODIC: periodic_reg <= cfg.data[2:0];
                    REG_GRID_X:   grid_reg[0]  <= cfg.data[5:0];
                    REG_GRID_Y:   grid_reg[1]  <= cfg.data[5:0];
                    REG_GRID_Z:   grid_reg[2]  <= cfg.data[5:0];
                    REG_LEN_X:    len_reg[0]   <= cfg.data;
                    REG_LEN_Y:    len_reg[1]   <= cfg.data;
                    REG_LEN_Z:    len_reg[2]   <= cfg.data;
                    REG_SITES:    sites_reg    <= cfg.data[4:0];
                    default:      sites_reg    <= sites_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        ok_reg      <= ok_next;
        sloti_reg   <= sloti_next;
        slotj_reg   <= slotj_next;
        ai_reg      <= ai_next;
        aj_reg      <= aj_next;
        vi_reg      <= vi_next;
        ostatus_reg <= ostatus_next;
        oai_reg     <= oai_next;
        oaj_reg     <= oaj_next;
        oti_reg     <= oti_next;
        olast_reg   <= olast_next;
        for (int a = 0; a < 3; a++)
        begin
            sh_reg[a]    <= sh_next[a];
            pi_reg[a]    <= pi_next[a];
            ovec_reg[a]  <= ovec_next[a];
            shift_reg[a] <= {26'd0, g_eff[a]} * {1'b0, len_reg[a]};
        end
        if (req.valid && req.ready)
        begin
            mode_reg   <= mode_t'(req.mode);
            c_reg[0]   <= req.cell_x;
            c_reg[1]   <= req.cell_y;
            c_reg[2]   <= req.cell_z;
            sa_in_reg  <= req.site_a;
            sb_in_reg  <= req.site_b;
            pos_reg[0] <= req.pos_x;
            pos_reg[1] <= req.pos_y;
            pos_reg[2] <= req.pos_z;
            off_reg[0] <= req.off_x;
            off_reg[1] <= req.off_y;
            off_reg[2] <= req.off_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tm_we)
            tmem[tcount_reg[TB-1:0]] <= tm_wdata;
        if (tm_re)
            tm_rdata <= tmem[tm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
            cmem[cm_waddr] <= acount_reg[AB-1:0];
        if (cm_re)
            cm_rdata <= cmem[cm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (am_we)
            amem[acount_reg[AB-1:0]] <= am_wdata;
        if (am_re)
            am_rdata <= amem[am_raddr];
    end

`ifndef NO_ASSERTIONS
    a_acount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acount_reg <= (AB+1)'(MAX_ATOMS))
        else $error("atom count past store depth");

    a_tcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg <= (TB+1)'(MAX_TEMPLATE))
        else $error("template count past table depth");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> ({1'b0, t_reg} < tcount_reg))
        else $error("template walk past last entry");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted word not dispatched");
`endif
endmodule
